### sv/calu_pkg.sv
// Shared types and constants for the flag-producing 8-bit processor ALU.
// Used by calu_exec, calu_merge and cpu_alu_with_flags_unit; no dependencies.

package calu_pkg;

   // Operation codes; the values 33 to 63 have no meaning and are handled by default arms.
   typedef enum logic [5:0] {
      FN_ADD    = 6'd0,
      FN_ADC    = 6'd1,
      FN_SUB    = 6'd2,
      FN_SBC    = 6'd3,
      FN_AND    = 6'd4,
      FN_XOR    = 6'd5,
      FN_OR     = 6'd6,
      FN_CP     = 6'd7,
      FN_INC8   = 6'd8,
      FN_DEC8   = 6'd9,
      FN_INC16  = 6'd10,
      FN_DEC16  = 6'd11,
      FN_ADD16  = 6'd12,
      FN_ADDSPE = 6'd13,
      FN_DAA    = 6'd14,
      FN_CPL    = 6'd15,
      FN_SCF    = 6'd16,
      FN_CCF    = 6'd17,
      FN_RLC    = 6'd18,
      FN_RL     = 6'd19,
      FN_RRC    = 6'd20,
      FN_RR     = 6'd21,
      FN_RLCA   = 6'd22,
      FN_RLA    = 6'd23,
      FN_RRCA   = 6'd24,
      FN_RRA    = 6'd25,
      FN_SLA    = 6'd26,
      FN_SRA    = 6'd27,
      FN_SWAP   = 6'd28,
      FN_SRL    = 6'd29,
      FN_BIT    = 6'd30,
      FN_RES    = 6'd31,
      FN_SET    = 6'd32
   } func_type;

   localparam logic [7:0] DAA_LOW_FIX   = 8'h06;
   localparam logic [7:0] DAA_HIGH_FIX  = 8'h60;
   localparam logic [7:0] DAA_BYTE_MAX  = 8'h99;
   localparam logic [3:0] DAA_NIB_MAX   = 4'd9;
   localparam logic [15:0] WIDE_ONE     = 16'h0001;
   localparam logic [15:0] WIDE_MINUS   = 16'hFFFF;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [5:0]  func;
      logic [7:0]  accumulator;
      logic [7:0]  operand;
      logic [15:0] wide_left;
      logic [15:0] wide_right;
      logic [2:0]  bit_index;
      logic        zero_in;
      logic        subtract_in;
      logic        half_in;
      logic        carry_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic [15:0] result_wide;
      logic        zero_out;
      logic        subtract_out;
      logic        half_out;
      logic        carry_out;
   } rsp_type;

   // First stage to second stage: byte result before decimal adjust, low half of the
   // 16-bit add and the operands of its high half.
   typedef struct packed {
      logic [7:0] byte_res;
      logic [7:0] adjust;
      logic [7:0] wide_lo;
      logic       wide_lo_cy;
      logic [7:0] left_hi;
      logic [7:0] right_hi;
      logic       wide_en;
      logic       wide_flags;
      logic       zero_from_res;
      flags_type  flags;
   } exec_type;

   // Second stage to output stage.
   typedef struct packed {
      logic [7:0]  byte_res;
      logic [15:0] wide_res;
      logic        zero_from_res;
      flags_type   flags;
   } merge_type;

endpackage

### sv/calu_exec.sv
// First pipeline stage: decodes the operation and runs the 8-bit datapath and the
// low byte of the 16-bit adder. Depends on calu_pkg.

module calu_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  calu_pkg::req_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output calu_pkg::exec_type out_data
);

   logic               valid_ff;
   logic               valid_in;
   calu_pkg::exec_type data_ff;
   calu_pkg::exec_type data_in;

   calu_pkg::func_type fn;
   logic [7:0]  a;
   logic [7:0]  v;
   logic        cin;
   logic        use_carry;
   logic [8:0]  sum9;
   logic [4:0]  hsum;
   logic [8:0]  diff9;
   logic [4:0]  hdiff;
   logic [7:0]  inc_v;
   logic [7:0]  dec_v;
   logic [15:0] right16;
   logic [8:0]  lo9;
   logic [4:0]  lo_nib;
   logic        acc_rot;
   logic [7:0]  rot_x;
   logic [7:0]  corr;
   logic        daa_cy;

   assign fn  = calu_pkg::func_type'(in_data.func);
   assign a   = in_data.accumulator;
   assign v   = in_data.operand;
   assign cin = in_data.carry_in;

   assign use_carry = cin && ((fn == calu_pkg::FN_ADC) || (fn == calu_pkg::FN_SBC));
   assign sum9  = {1'b0, a} + {1'b0, v} + {8'd0, use_carry};
   assign hsum  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_carry};
   assign diff9 = {1'b0, a} - {1'b0, v} - {8'd0, use_carry};
   assign hdiff = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_carry};
   assign inc_v = v + 8'd1;
   assign dec_v = v - 8'd1;

   always_comb begin
      unique case (fn)
         calu_pkg::FN_INC16:  right16 = calu_pkg::WIDE_ONE;
         calu_pkg::FN_DEC16:  right16 = calu_pkg::WIDE_MINUS;
         calu_pkg::FN_ADD16:  right16 = in_data.wide_right;
         calu_pkg::FN_ADDSPE: right16 = {{8{v[7]}}, v};
         default:             right16 = '0;
      endcase
   end

   assign lo9    = {1'b0, in_data.wide_left[7:0]} + {1'b0, right16[7:0]};
   assign lo_nib = {1'b0, in_data.wide_left[3:0]} + {1'b0, right16[3:0]};

   assign acc_rot = (fn == calu_pkg::FN_RLCA) || (fn == calu_pkg::FN_RLA) ||
                    (fn == calu_pkg::FN_RRCA) || (fn == calu_pkg::FN_RRA);
   assign rot_x   = acc_rot ? a : v;

   // Decimal adjust: the correction is chosen here and applied in the next stage.
   always_comb begin
      corr   = '0;
      daa_cy = cin;
      if (in_data.half_in || (!in_data.subtract_in && (a[3:0] > calu_pkg::DAA_NIB_MAX))) begin
         corr = corr | calu_pkg::DAA_LOW_FIX;
      end
      if (cin || (!in_data.subtract_in && (a > calu_pkg::DAA_BYTE_MAX))) begin
         corr   = corr | calu_pkg::DAA_HIGH_FIX;
         daa_cy = 1'b1;
      end
   end

   always_comb begin
      data_in               = '0;
      data_in.flags.z       = in_data.zero_in;
      data_in.flags.n       = in_data.subtract_in;
      data_in.flags.h       = in_data.half_in;
      data_in.flags.c       = cin;
      data_in.wide_lo       = lo9[7:0];
      data_in.wide_lo_cy    = lo9[8];
      data_in.left_hi       = in_data.wide_left[15:8];
      data_in.right_hi      = right16[15:8];
      unique case (fn)
         calu_pkg::FN_ADD, calu_pkg::FN_ADC: begin
            data_in.byte_res      = sum9[7:0];
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = hsum[4];
            data_in.flags.c       = sum9[8];
         end
         calu_pkg::FN_SUB, calu_pkg::FN_SBC, calu_pkg::FN_CP: begin
            data_in.byte_res      = diff9[7:0];
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b1;
            data_in.flags.h       = hdiff[4];
            data_in.flags.c       = diff9[8];
            // Compare sets the flags from the difference but hands back the accumulator.
            if (fn == calu_pkg::FN_CP) begin
               data_in.byte_res      = a;
               data_in.zero_from_res = 1'b0;
               data_in.flags.z       = (diff9[7:0] == 8'd0);
            end
         end
         calu_pkg::FN_AND: begin
            data_in.byte_res      = a & v;
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b1;
            data_in.flags.c       = 1'b0;
         end
         calu_pkg::FN_XOR: begin
            data_in.byte_res      = a ^ v;
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = 1'b0;
         end
         calu_pkg::FN_OR: begin
            data_in.byte_res      = a | v;
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = 1'b0;
         end
         calu_pkg::FN_INC8: begin
            data_in.byte_res      = inc_v;
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = (inc_v[3:0] == 4'h0);
         end
         calu_pkg::FN_DEC8: begin
            data_in.byte_res      = dec_v;
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b1;
            data_in.flags.h       = (dec_v[3:0] == 4'hF);
         end
         calu_pkg::FN_INC16, calu_pkg::FN_DEC16: begin
            data_in.wide_en = 1'b1;
         end
         calu_pkg::FN_ADD16: begin
            data_in.wide_en    = 1'b1;
            data_in.wide_flags = 1'b1;
            data_in.flags.n    = 1'b0;
         end
         calu_pkg::FN_ADDSPE: begin
            data_in.wide_en = 1'b1;
            data_in.flags.z = 1'b0;
            data_in.flags.n = 1'b0;
            data_in.flags.h = lo_nib[4];
            data_in.flags.c = lo9[8];
         end
         calu_pkg::FN_DAA: begin
            data_in.byte_res      = a;
            data_in.adjust        = in_data.subtract_in ? (8'd0 - corr) : corr;
            data_in.zero_from_res = 1'b1;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = daa_cy;
         end
         calu_pkg::FN_CPL: begin
            data_in.byte_res = ~a;
            data_in.flags.n  = 1'b1;
            data_in.flags.h  = 1'b1;
         end
         calu_pkg::FN_SCF: begin
            data_in.flags.n = 1'b0;
            data_in.flags.h = 1'b0;
            data_in.flags.c = 1'b1;
         end
         calu_pkg::FN_CCF: begin
            data_in.flags.n = 1'b0;
            data_in.flags.h = 1'b0;
            data_in.flags.c = ~cin;
         end
         calu_pkg::FN_RLC, calu_pkg::FN_RLCA: begin
            data_in.byte_res      = {rot_x[6:0], rot_x[7]};
            data_in.zero_from_res = !acc_rot;
            data_in.flags.z       = 1'b0;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = rot_x[7];
         end
         calu_pkg::FN_RL, calu_pkg::FN_RLA: begin
            data_in.byte_res      = {rot_x[6:0], cin};
            data_in.zero_from_res = !acc_rot;
            data_in.flags.z       = 1'b0;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = rot_x[7];
         end
         calu_pkg::FN_RRC, calu_pkg::FN_RRCA: begin
            data_in.byte_res      = {rot_x[0], rot_x[7:1]};
            data_in.zero_from_res = !acc_rot;
            data_in.flags.z       = 1'b0;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = rot_x[0];
         end
         calu_pkg::FN_RR, calu_pkg::FN_RRA: begin
            data_in.byte_res      = {cin, rot_x[7:1]};
            data_in.zero_from_res = !acc_rot;
            data_in.flags.z       = 1'b0;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = rot_x[0];
         end
         calu_pkg::FN_SLA: begin
            data_in.byte_res      = {v[6:0], 1'b0};
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = v[7];
         end
         calu_pkg::FN_SRA: begin
            data_in.byte_res      = {v[7], v[7:1]};
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = v[0];
         end
         calu_pkg::FN_SWAP: begin
            data_in.byte_res      = {v[3:0], v[7:4]};
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = 1'b0;
         end
         calu_pkg::FN_SRL: begin
            data_in.byte_res      = {1'b0, v[7:1]};
            data_in.zero_from_res = 1'b1;
            data_in.flags.n       = 1'b0;
            data_in.flags.h       = 1'b0;
            data_in.flags.c       = v[0];
         end
         calu_pkg::FN_BIT: begin
            data_in.byte_res = a;
            data_in.flags.z  = !v[in_data.bit_index];
            data_in.flags.n  = 1'b0;
            data_in.flags.h  = 1'b1;
         end
         calu_pkg::FN_RES: begin
            data_in.byte_res = v & ~(8'd1 << in_data.bit_index);
         end
         calu_pkg::FN_SET: begin
            data_in.byte_res = v | (8'd1 << in_data.bit_index);
         end
         default: begin
            data_in.byte_res = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/calu_merge.sv
// Second pipeline stage: high byte of the 16-bit adder, decimal adjust and final
// selection of the byte, wide result and flags. Depends on calu_pkg.

module calu_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  calu_pkg::exec_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output calu_pkg::merge_type out_data
);

   logic                valid_ff;
   logic                valid_in;
   calu_pkg::merge_type data_ff;
   calu_pkg::merge_type data_in;
   logic [8:0]          hi9;
   logic [4:0]          hi_nib;

   assign hi9    = {1'b0, in_data.left_hi} + {1'b0, in_data.right_hi} +
                   {8'd0, in_data.wide_lo_cy};
   assign hi_nib = {1'b0, in_data.left_hi[3:0]} + {1'b0, in_data.right_hi[3:0]} +
                   {4'd0, in_data.wide_lo_cy};

   always_comb begin
      data_in.byte_res      = in_data.byte_res + in_data.adjust;
      data_in.wide_res      = in_data.wide_en ? {hi9[7:0], in_data.wide_lo} : 16'd0;
      data_in.zero_from_res = in_data.zero_from_res;
      data_in.flags         = in_data.flags;
      // The 16-bit add takes half carry from bit 11 and carry from bit 15.
      if (in_data.wide_flags) begin
         data_in.flags.h = hi_nib[4];
         data_in.flags.c = hi9[8];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/cpu_alu_with_flags_unit.sv
// A request is registered by the first stage, then the second, then the output register.
// Throughput: one request per cycle while rsp_ready is high; the ALU is a three-stage
// pipeline (decode and 8-bit datapath, 16-bit high byte and decimal adjust, zero flag and
// output register). The response waits there until rsp_ready takes it.
// Ready runs back from rsp_ready through each stage, so a stalled stage holds its data.
// Synchronous reset clears every stage's valid bit; data registers are not reset.
// Depends on calu_pkg, calu_exec and calu_merge.

module cpu_alu_with_flags_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  calu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output calu_pkg::rsp_type rsp_data
);

   logic                s1_valid;
   logic                s1_ready;
   calu_pkg::exec_type  s1_data;
   logic                s2_valid;
   logic                s2_ready;
   calu_pkg::merge_type s2_data;
   logic                valid_ff;
   logic                valid_in;
   calu_pkg::rsp_type   data_ff;
   calu_pkg::rsp_type   data_in;

   calu_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   calu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   always_comb begin
      data_in.result_byte  = s2_data.byte_res;
      data_in.result_wide  = s2_data.wide_res;
      data_in.zero_out     = s2_data.zero_from_res ? (s2_data.byte_res == 8'd0)
                                                   : s2_data.flags.z;
      data_in.subtract_out = s2_data.flags.n;
      data_in.half_out     = s2_data.flags.h;
      data_in.carry_out    = s2_data.flags.c;
   end

   assign s2_ready = !valid_ff || rsp_ready;
   assign valid_in = s2_ready ? s2_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid && s2_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Nothing is left in flight straight after reset.
   assert property (@(posedge clock) reset |=> (!rsp_valid && !s1_valid && !s2_valid))
      else $error("pipeline holds a request after reset");

   // The input side can only stall when every stage is full and the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid && s2_valid && rsp_valid && !rsp_ready))
      else $error("input stalled while the pipeline has room");

   // An accepted request always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid)
      else $error("accepted request lost at the first stage");

   // Only 16-bit operations give a wide result, and they leave the byte result at zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_wide != 16'd0)) |-> (rsp_data.result_byte == 8'd0))
      else $error("byte and wide results both non-zero");

endmodule

### tb/sv/tb_cpu_alu_with_flags_unit.sv
// Self-checking testbench for cpu_alu_with_flags_unit: every request is predicted and
// every response is compared field by field, under several patterns of idling and stalls.
// Depends on calu_pkg and the cpu_alu_with_flags_unit RTL.
`timescale 1ns / 100ps

module tb_cpu_alu_with_flags_unit;
   import calu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 488;
   localparam int SETTLE_CYCLES  = 10;

   class alu_scoreboard;
      rsp_type awaited_q[$];
      int      failures = 0;

      function automatic rsp_type compute_result(req_type q);
         rsp_type     s;
         logic [7:0]  a, v, x, r, corr;
         logic [15:0] w;
         logic [4:0]  nib;
         logic [8:0]  sum9;
         logic [12:0] sum13;
         logic [16:0] sum17;
         logic        z, n, h, c, t, acc_rot;
         a = q.accumulator;
         v = q.operand;
         z = q.zero_in;
         n = q.subtract_in;
         h = q.half_in;
         c = q.carry_in;
         r = 8'h00;
         w = 16'h0000;
         acc_rot = (q.func >= FN_RLCA) && (q.func <= FN_RRA);
         x = acc_rot ? a : v;
         case (q.func)
            FN_ADD, FN_ADC: begin
               t = (q.func == FN_ADC) ? c : 1'b0;
               nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + 5'(t);
               sum9 = {1'b0, a} + {1'b0, v} + 9'(t);
               h = nib[4];
               c = sum9[8];
               r = sum9[7:0];
               z = (r == 8'h00);
               n = 1'b0;
            end
            FN_SUB, FN_SBC, FN_CP: begin
               t = (q.func == FN_SBC) ? c : 1'b0;
               h = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + 5'(t));
               c = {1'b0, a} < ({1'b0, v} + 9'(t));
               r = a - v - 8'(t);
               z = (r == 8'h00);
               n = 1'b1;
               // Compare only sets flags; the accumulator comes back untouched.
               if (q.func == FN_CP) r = a;
            end
            FN_AND: begin
               r = a & v; z = (r == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
            end
            FN_XOR: begin
               r = a ^ v; z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            FN_OR: begin
               r = a | v; z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            FN_INC8: begin
               r = v + 8'h01; z = (r == 8'h00); n = 1'b0; h = (r[3:0] == 4'h0);
            end
            FN_DEC8: begin
               r = v - 8'h01; z = (r == 8'h00); n = 1'b1; h = (r[3:0] == 4'hF);
            end
            FN_INC16: w = q.wide_left + 16'h0001;
            FN_DEC16: w = q.wide_left - 16'h0001;
            FN_ADD16: begin
               sum13 = {1'b0, q.wide_left[11:0]} + {1'b0, q.wide_right[11:0]};
               sum17 = {1'b0, q.wide_left} + {1'b0, q.wide_right};
               n = 1'b0;
               h = sum13[12];
               c = sum17[16];
               w = sum17[15:0];
            end
            FN_ADDSPE: begin
               // Flags come from the unsigned add on the low byte only.
               nib = {1'b0, q.wide_left[3:0]} + {1'b0, v[3:0]};
               sum9 = {1'b0, q.wide_left[7:0]} + {1'b0, v};
               z = 1'b0;
               n = 1'b0;
               h = nib[4];
               c = sum9[8];
               w = q.wide_left + {{8{v[7]}}, v};
            end
            FN_DAA: begin
               corr = 8'h00;
               if (h || (!n && (a[3:0] > DAA_NIB_MAX))) corr = corr | DAA_LOW_FIX;
               if (c || (!n && (a > DAA_BYTE_MAX))) begin
                  corr = corr | DAA_HIGH_FIX;
                  c = 1'b1;
               end
               r = n ? (a - corr) : (a + corr);
               z = (r == 8'h00);
               h = 1'b0;
            end
            FN_CPL: begin
               r = ~a; n = 1'b1; h = 1'b1;
            end
            FN_SCF: begin
               n = 1'b0; h = 1'b0; c = 1'b1;
            end
            FN_CCF: begin
               n = 1'b0; h = 1'b0; c = ~c;
            end
            FN_RLC, FN_RL, FN_RRC, FN_RR, FN_RLCA, FN_RLA, FN_RRCA, FN_RRA: begin
               case (q.func)
                  FN_RLC, FN_RLCA: begin
                     t = x[7]; r = {x[6:0], x[7]};
                  end
                  FN_RL, FN_RLA: begin
                     t = x[7]; r = {x[6:0], c};
                  end
                  FN_RRC, FN_RRCA: begin
                     t = x[0]; r = {x[0], x[7:1]};
                  end
                  default: begin
                     t = x[0]; r = {c, x[7:1]};
                  end
               endcase
               c = t;
               n = 1'b0;
               h = 1'b0;
               // The accumulator forms always clear zero.
               z = acc_rot ? 1'b0 : (r == 8'h00);
            end
            FN_SLA: begin
               c = v[7]; r = {v[6:0], 1'b0}; z = (r == 8'h00); n = 1'b0; h = 1'b0;
            end
            FN_SRA: begin
               c = v[0]; r = {v[7], v[7:1]}; z = (r == 8'h00); n = 1'b0; h = 1'b0;
            end
            FN_SWAP: begin
               r = {v[3:0], v[7:4]}; z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            FN_SRL: begin
               c = v[0]; r = {1'b0, v[7:1]}; z = (r == 8'h00); n = 1'b0; h = 1'b0;
            end
            FN_BIT: begin
               r = a; z = ~v[q.bit_index]; n = 1'b0; h = 1'b1;
            end
            FN_RES: begin
               r = v; r[q.bit_index] = 1'b0;
            end
            FN_SET: begin
               r = v; r[q.bit_index] = 1'b1;
            end
            default: ;
         endcase
         s.result_byte  = r;
         s.result_wide  = w;
         s.zero_out     = z;
         s.subtract_out = n;
         s.half_out     = h;
         s.carry_out    = c;
         return s;
      endfunction

      function void note_request(req_type q);
         awaited_q.push_back(compute_result(q));
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_q.size() == 0) begin
            $error("response with no request outstanding: 0x%0h", got);
            failures++;
         end else begin
            want = awaited_q.pop_front();
            check_field("result_byte", want.result_byte, got.result_byte);
            check_field("result_wide", want.result_wide, got.result_wide);
            check_field("zero_out", want.zero_out, got.zero_out);
            check_field("subtract_out", want.subtract_out, got.subtract_out);
            check_field("half_out", want.half_out, got.half_out);
            check_field("carry_out", want.carry_out, got.carry_out);
         end
      endfunction

      function int outstanding();
         return awaited_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   alu_scoreboard sb = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   cpu_alu_with_flags_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // Ends the run if neither channel moves for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A};
      if ($urandom_range(3) == 0) return corners[$urandom_range(7)];
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_wide();
      logic [15:0] corners[6] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h1000, 16'h7FFF, 16'h80FF};
      if ($urandom_range(3) == 0) return corners[$urandom_range(5)];
      return 16'($urandom);
   endfunction

   function automatic req_type random_request();
      req_type q;
      // Mostly defined operations, with a few undefined codes mixed in.
      if ($urandom_range(19) == 0) q.func = 6'($urandom_range(63, 33));
      else q.func = 6'($urandom_range(32));
      q.accumulator = pick_byte();
      q.operand     = pick_byte();
      q.wide_left   = pick_wide();
      q.wide_right  = pick_wide();
      q.bit_index   = 3'($urandom);
      q.zero_in     = 1'($urandom);
      q.subtract_in = 1'($urandom);
      q.half_in     = 1'($urandom);
      q.carry_in    = 1'($urandom);
      return q;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input req_type q);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      sb.note_request(q);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   initial begin
      req_type q;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Each operation code once, alternating all-ones and all-zeros operands and flags.
      for (int k = 0; k <= 34; k++) begin
         q = (k % 2 == 0) ? '1 : '0;
         q.func = (k <= 32) ? 6'(k) : ((k == 33) ? 6'd33 : 6'd63);
         send_request(q);
      end
      // Decimal adjust corners: above 0x99 on add, and both corrections on subtract.
      q = '0;
      q.func = FN_DAA;
      q.accumulator = 8'h9A;
      send_request(q);
      q.subtract_in = 1'b1;
      q.half_in = 1'b1;
      q.carry_in = 1'b1;
      q.accumulator = 8'h00;
      send_request(q);
      drain_responses();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = (phase == 1) ? 64 : ((phase == 3) ? 19 : 0);
         receiver_stall_pct = (phase == 2) ? 64 : ((phase == 3) ? 19 : 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(random_request());
            // Halfway through, hold requests back until the pipeline has emptied.
            if (i == PHASE_ITEMS / 2) drain_responses();
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
sv/calu_pkg.sv
sv/calu_exec.sv
sv/calu_merge.sv
sv/cpu_alu_with_flags_unit.sv
tb/sv/tb_cpu_alu_with_flags_unit.sv
